/* rtl/tli_pkg.sv */
// shared types and constants for the table linear interpolator
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package tli_pkg;

    // storage dimensions
    localparam int GRID_POINTS = 64;
    localparam int WAVES       = 16;
    localparam int GRID_AW     = $clog2(GRID_POINTS);
    localparam int WAVE_AW     = $clog2(WAVES);
    localparam int COEF_AW     = GRID_AW + WAVE_AW;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVES  = 2'd1;
    localparam logic [6:0] POINTS_RESET = 7'd64;
    localparam logic [4:0] WAVES_RESET  = 5'd16;

    // serial arithmetic step counts
    localparam int MUL_STEPS = 33;
    localparam int DIV_STEPS = 66;
    localparam int CNT_W     = 7;

    // item kinds
    typedef enum logic [1:0] {
        CMD_WR_GRID = 2'd0,
        CMD_WR_COEF = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_code_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_SEG  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;
    localparam logic [1:0] ST_BAD_WAVE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FETCH0,
        S_FETCH1,
        S_FETCH2,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        RD_IE,
        RD_LO,
        RD_HI
    } rd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    ie_inc;
        rd_sel_t rd_sel;
        logic    cap_lo;
        logic    cap_hi;
        logic    diff_load;
        logic    mul_step;
        logic    div_step;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic wave_bad;
        logic ie_last;
        logic grid_gt;
        logic de_zero;
        logic mul_last;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/tli_ctrl.sv */
// controller state machine: sequences search, fetch, multiply, divide and output
// depends on tli_pkg
`default_nettype none

module tli_ctrl import tli_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire logic [1:0] in_command,
    output logic           in_ready,
    output dp_cmd_t        cmd,
    input  dp_stat_t       stat
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_IE;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && (cmd_code_t'(in_command) == CMD_QUERY)) begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_sel = RD_IE;
                if (stat.wave_bad) begin
                    state_next = S_FIN;
                end else if (stat.ie_last) begin
                    state_next = S_FETCH0;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (stat.grid_gt) begin
                    state_next = S_FETCH0;
                end else begin
                    cmd.ie_inc = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_FETCH0: begin
                cmd.rd_sel = RD_LO;
                state_next = S_FETCH1;
            end
            S_FETCH1: begin
                cmd.rd_sel = RD_HI;
                cmd.cap_lo = 1'b1;
                state_next = S_FETCH2;
            end
            S_FETCH2: begin
                cmd.cap_hi = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = stat.de_zero ? S_FIN : S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tli_dpath.sv */
// datapath: grid and coefficient memories, search index, serial multiply and divide,
// result saturation and output register; depends on tli_pkg
`default_nettype none

module tli_dpath import tli_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0]  cfg_wdata,
    input  wire logic [1:0]         in_command,
    input  wire logic               in_branch_down,
    input  wire logic [GRID_AW-1:0] in_grid_index,
    input  wire logic [WAVE_AW-1:0] in_partial_wave,
    input  wire logic [5:0]         in_j_doubled,
    input  wire logic [31:0]        in_data_value,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [31:0]             out_coefficient,
    output logic [1:0]              out_status,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat
);

    // configuration registers
    logic [6:0] points_reg;
    logic [4:0] waves_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= POINTS_RESET;
            waves_reg  <= WAVES_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_POINTS) begin
                points_reg <= cfg_wdata;
            end else if (cfg_index == CFG_WAVES) begin
                waves_reg <= cfg_wdata[4:0];
            end
        end
    end

    // clamped limits
    logic [GRID_AW-1:0] last_idx;
    logic [5:0]         waves_eff;

    always_comb begin
        if (points_reg < 7'd2) begin
            last_idx = GRID_AW'(1);
        end else if (points_reg > 7'(GRID_POINTS)) begin
            last_idx = GRID_AW'(GRID_POINTS - 1);
        end else begin
            last_idx = GRID_AW'(points_reg - 7'd1);
        end
        if (waves_reg == 5'd0) begin
            waves_eff = 6'd1;
        end else if ({1'b0, waves_reg} > 6'(WAVES)) begin
            waves_eff = 6'(WAVES);
        end else begin
            waves_eff = {1'b0, waves_reg};
        end
    end

    // query latch
    logic [WAVE_AW-1:0] l_reg;
    logic               up_reg;
    logic signed [31:0] val_reg;
    logic               bad_reg;
    logic               is_query;
    logic               wr_grid;
    logic               wr_coef;

    assign is_query = cmd.accept && (cmd_code_t'(in_command) == CMD_QUERY);
    assign wr_grid  = cmd.accept && (cmd_code_t'(in_command) == CMD_WR_GRID);
    assign wr_coef  = cmd.accept && (cmd_code_t'(in_command) == CMD_WR_COEF);

    always_ff @(posedge aclk) begin
        if (is_query) begin
            l_reg   <= in_partial_wave;
            up_reg  <= (in_j_doubled[5:1] == 5'(in_partial_wave));
            val_reg <= in_data_value;
            bad_reg <= (6'(in_partial_wave) >= waves_eff);
        end
    end

    // search index
    logic [GRID_AW-1:0] ie_reg;
    logic [GRID_AW-1:0] ie_eff;

    always_ff @(posedge aclk) begin
        if (is_query) begin
            ie_reg <= '0;
        end else if (cmd.ie_inc) begin
            ie_reg <= ie_reg + GRID_AW'(1);
        end
    end

    assign ie_eff = (ie_reg == '0) ? GRID_AW'(1) : ie_reg;

    // memory read address
    logic [GRID_AW-1:0] rd_addr;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_LO:   rd_addr = ie_eff - GRID_AW'(1);
            RD_HI:   rd_addr = ie_eff;
            default: rd_addr = ie_reg;
        endcase
    end

    // memories, written on input transfer, read data registered
    logic [31:0] grid_mem [GRID_POINTS];
    logic [31:0] up_mem   [WAVES*GRID_POINTS];
    logic [31:0] down_mem [WAVES*GRID_POINTS];
    logic [31:0] grid_q_reg;
    logic [31:0] up_q_reg;
    logic [31:0] down_q_reg;
    logic [COEF_AW-1:0] wr_caddr;
    logic [COEF_AW-1:0] rd_caddr;

    assign wr_caddr = {in_partial_wave, in_grid_index};
    assign rd_caddr = {l_reg, rd_addr};

    always_ff @(posedge aclk) begin
        if (wr_grid) begin
            grid_mem[in_grid_index] <= in_data_value;
        end
        grid_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_coef && !in_branch_down) begin
            up_mem[wr_caddr] <= in_data_value[31] ? 32'd0 : in_data_value;
        end
        up_q_reg <= up_mem[rd_caddr];
    end

    always_ff @(posedge aclk) begin
        if (wr_coef && in_branch_down) begin
            down_mem[wr_caddr] <= in_data_value;
        end
        down_q_reg <= down_mem[rd_caddr];
    end

    // segment end points
    logic signed [31:0] e0_reg, e1_reg, t0_reg, t1_reg;
    logic        [31:0] t_q;

    assign t_q = up_reg ? up_q_reg : down_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_lo) begin
            e0_reg <= grid_q_reg;
            t0_reg <= t_q;
        end
        if (cmd.cap_hi) begin
            e1_reg <= grid_q_reg;
            t1_reg <= t_q;
        end
    end

    // differences, 33 bits exact
    logic signed [32:0] dt, de, dx;
    logic        [32:0] dt_mag, de_mag, dx_mag;

    assign dt     = 33'(t1_reg) - 33'(t0_reg);
    assign de     = 33'(e1_reg) - 33'(e0_reg);
    assign dx     = 33'(val_reg) - 33'(e0_reg);
    assign dt_mag = dt[32] ? -dt : dt;
    assign de_mag = de[32] ? -de : de;
    assign dx_mag = dx[32] ? -dx : dx;

    // serial shift-add multiply then restoring divide, sharing one product register
    logic [66:0] p_reg;
    logic [32:0] mcand_reg;
    logic [32:0] dvsr_reg;
    logic [32:0] rem_reg;
    logic        neg_reg;
    logic        zw_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [33:0] mul_hi;
    logic [33:0] div_r2;
    logic        div_ge;

    assign mul_hi = p_reg[66:33] + (p_reg[0] ? {1'b0, mcand_reg} : 34'd0);
    assign div_r2 = {rem_reg, p_reg[65]};
    assign div_ge = div_r2 >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (cmd.diff_load) begin
            p_reg     <= {34'd0, dx_mag};
            mcand_reg <= dt_mag;
            dvsr_reg  <= de_mag;
            neg_reg   <= dt[32] ^ dx[32] ^ de[32];
            zw_reg    <= (de == '0);
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end else if (cmd.mul_step) begin
            p_reg   <= {1'b0, mul_hi, p_reg[32:1]};
            cnt_reg <= stat.mul_last ? '0 : cnt_reg + CNT_W'(1);
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? 33'(div_r2 - {1'b0, dvsr_reg}) : div_r2[32:0];
            p_reg   <= {1'b0, p_reg[64:0], div_ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // result formation and saturation
    logic        q_ovf;
    logic [33:0] q_mag;
    logic signed [35:0] sum;
    logic [31:0] res;
    logic [1:0]  res_st;

    assign q_ovf = (p_reg[65:34] != '0) || (p_reg[33] && (p_reg[32:0] != '0));
    assign q_mag = p_reg[33:0];
    assign sum   = 36'(t0_reg) + (neg_reg ? -36'(q_mag) : 36'(q_mag));

    always_comb begin
        if (bad_reg) begin
            res    = 32'd0;
            res_st = ST_BAD_WAVE;
        end else if (zw_reg) begin
            res    = t0_reg;
            res_st = ST_ZERO_SEG;
        end else if (q_ovf) begin
            res    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res_st = ST_SATURATED;
        end else if (sum > 36'sh0_7FFF_FFFF) begin
            res    = 32'h7FFF_FFFF;
            res_st = ST_SATURATED;
        end else if (sum < -36'sh0_8000_0000) begin
            res    = 32'h8000_0000;
            res_st = ST_SATURATED;
        end else begin
            res    = sum[31:0];
            res_st = ST_OK;
        end
    end

    // output register
    logic        ov_reg;
    logic [31:0] ocoef_reg;
    logic [1:0]  ost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            ocoef_reg <= res;
            ost_reg   <= res_st;
        end
    end

    assign out_valid       = ov_reg;
    assign out_coefficient = ocoef_reg;
    assign out_status      = ost_reg;

    // status to controller
    always_comb begin
        stat          = '0;
        stat.wave_bad = bad_reg;
        stat.ie_last  = (ie_reg == last_idx);
        stat.grid_gt  = $signed(grid_q_reg) > val_reg;
        stat.de_zero  = (e1_reg == e0_reg);
        stat.mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));
        stat.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        stat.out_free = !ov_reg || out_ready;
    end

endmodule

`default_nettype wire

/* rtl/table_linear_interpolator_core.sv */
// top level of the table linear interpolator: unpacks the stream channels
// and joins tli_ctrl and tli_dpath; depends on tli_pkg
//
//  channel  direction  tdata                                         tuser
//  s_       in         grid_index, partial_wave, j_doubled, value    command, branch_down
//  m_       out        coefficient                                   status
//  cfg_     in         write enable, index 0 points, 1 waves         -
//
// writes complete on their transfer; a query scans grid points, fetches the segment
// and forms the differences, runs the serial multiply and the restoring divide, and
// loads the output. a zero-width segment skips multiply and divide; a wave out of
// range goes from the first scan step straight to the output load.
// reset clears state and configuration; memories hold garbage until written.
// a finished result waits in the output register; the next item is taken
// meanwhile, and a later query holds in its last step until that transfer.
`default_nettype none

module table_linear_interpolator_core import tli_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // grid_index[5:0], partial_wave[9:6], j_doubled[15:10], data_value[47:16]
    input  wire logic [47:0]          s_tdata,
    // command[1:0], branch_down[2]
    input  wire logic [2:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // coefficient[31:0]
    output logic [31:0]               m_tdata,
    // status[1:0]
    output logic [1:0]                m_tuser
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    tli_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (s_tuser[1:0]),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // storage and arithmetic
    tli_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_command      (s_tuser[1:0]),
        .in_branch_down  (s_tuser[2]),
        .in_grid_index   (s_tdata[5:0]),
        .in_partial_wave (s_tdata[9:6]),
        .in_j_doubled    (s_tdata[15:10]),
        .in_data_value   (s_tdata[47:16]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_coefficient (m_tdata),
        .out_status      (m_tuser),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

`default_nettype wire
